// ----- hdl/rfa_pkg.sv -----
// Shared types, constants and helper functions for the repulsive field accumulator.
// No dependencies.
package rfa_pkg;

   localparam int COORD_W   = 32;
   localparam int SUM_W     = 48;
   localparam int CFG_W     = 31;
   localparam int CSR_IDX_W = 2;
   localparam int INV_W     = 49;

   localparam logic [COORD_W-1:0] DIST_FLOOR   = COORD_W'(65);
   localparam logic [CFG_W-1:0]   SAFETY_RESET = CFG_W'(1966080);
   localparam logic [CFG_W-1:0]   GAIN_RESET   = CFG_W'(65536);

   localparam logic [63:0] U64_MAX  = {64{1'b1}};
   localparam logic [63:0] POS_CAP  = {{(64-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
   localparam logic [63:0] NEG_CAP  = {{(64-SUM_W){1'b0}}, 1'b1, {(SUM_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_SAFETY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RGAIN  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_AGAIN  = CSR_IDX_W'(2);

   typedef enum logic [1:0] {SH0, SH16, SH32} shift_type;

   typedef struct packed {
      logic                occupied;
      logic [COORD_W-1:0]  point_x;
      logic [COORD_W-1:0]  point_y;
      logic [COORD_W-1:0]  point_z;
      logic                last_cell;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] accel_x;
      logic [SUM_W-1:0] accel_y;
      logic [SUM_W-1:0] accel_z;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      shift_type   shift;
      logic [63:0] cap;
   } mul_cmd_type;

   function automatic logic [SUM_W-1:0] apply_sign(input logic [63:0] mag, input logic neg);
      logic [SUM_W-1:0] m;
      m = mag[SUM_W-1:0];
      return neg ? (~m + SUM_W'(1)) : m;
   endfunction

   function automatic logic [63:0] mag_of(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] m;
      m = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
      return {{(64-SUM_W){1'b0}}, m};
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         return s[SUM_W] ? NEG_CAP[SUM_W-1:0] : POS_CAP[SUM_W-1:0];
      end
      return s[SUM_W-1:0];
   endfunction

endpackage

// ----- hdl/rfa_mul.sv -----
// Shared 64x64 multiply unit: four 32x32 partial products, shift and cap.
// Depends on rfa_pkg.
module rfa_mul import rfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output logic        done,
   output logic [63:0] result
);

   logic [63:0]  a_ff, b_ff, cap_ff, res_ff, prod_ff;
   shift_type    shift_ff;
   logic [127:0] acc_ff, acc_add;
   logic [2:0]   step_ff;
   logic [1:0]   off_ff;
   logic         busy_ff, done_ff;
   logic [31:0]  ha, hb;
   logic [63:0]  rlo;
   logic         over;

   assign ha = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign hb = step_ff[0] ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      case (off_ff)
         2'd0:    acc_add = {64'b0, prod_ff};
         2'd1:    acc_add = {32'b0, prod_ff, 32'b0};
         default: acc_add = {prod_ff, 64'b0};
      endcase
      case (shift_ff)
         SH0: begin
            rlo  = acc_ff[63:0];
            over = |acc_ff[127:64];
         end
         SH16: begin
            rlo  = acc_ff[79:16];
            over = |acc_ff[127:80];
         end
         default: begin
            rlo  = acc_ff[95:32];
            over = |acc_ff[127:96];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            a_ff     <= cmd.a;
            b_ff     <= cmd.b;
            cap_ff   <= cmd.cap;
            shift_ff <= cmd.shift;
            acc_ff   <= '0;
            step_ff  <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            if (step_ff < 3'd4) begin
               prod_ff <= 64'(ha) * 64'(hb);
               off_ff  <= 2'(step_ff[1]) + 2'(step_ff[0]);
            end
            if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
               acc_ff <= acc_ff + acc_add;
            end
            if (step_ff == 3'd5) begin
               res_ff  <= (over || rlo > cap_ff) ? cap_ff : rlo;
               done_ff <= 1'b1;
               busy_ff <= 1'b0;
            end
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ----- hdl/rfa_isqrt.sv -----
// Digit-by-digit integer square root of a 64-bit value, one result bit per cycle.
// Depends on rfa_pkg.
module rfa_isqrt import rfa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [63:0]        radicand,
   output logic               done,
   output logic [COORD_W-1:0] root
);

   logic [63:0]        n_ff;
   logic [34:0]        rem_ff, rem_t, trial;
   logic [31:0]        root_ff;
   logic [4:0]         cnt_ff;
   logic               busy_ff, done_ff;

   assign rem_t = {rem_ff[32:0], n_ff[63:62]};
   assign trial = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            n_ff    <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            n_ff <= {n_ff[61:0], 2'b00};
            if (rem_t >= trial) begin
               rem_ff  <= rem_t - trial;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= rem_t;
               root_ff <= {root_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- hdl/rfa_div.sv -----
// Restoring divider for 2^48 / den, one quotient bit per cycle.
// Depends on rfa_pkg.
module rfa_div import rfa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] den,
   output logic               done,
   output logic [INV_W-1:0]   quotient
);

   logic [COORD_W-1:0] den_ff;
   logic [COORD_W:0]   rem_ff, rem_t;
   logic [INV_W-1:0]   q_ff;
   logic [5:0]         cnt_ff;
   logic               busy_ff, done_ff;

   assign rem_t = {rem_ff[COORD_W-1:0], (cnt_ff == 6'd0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            den_ff  <= den;
            rem_ff  <= '0;
            q_ff    <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (rem_t >= {1'b0, den_ff}) begin
               rem_ff <= rem_t - {1'b0, den_ff};
               q_ff   <= {q_ff[INV_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_t;
               q_ff   <= {q_ff[INV_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(INV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- hdl/repulsive_field_accumulator_core.sv -----
// Top level: sequencer around one shared multiplier, a root unit and a divider.
// Depends on rfa_pkg, rfa_mul, rfa_isqrt, rfa_div.
//
//   channel | ports                       | direction
//   req     | req_valid/req_ready/req_data | cell word in
//   rsp     | rsp_valid/rsp_ready/rsp_data | acceleration word out
//   csr     | csr_we/csr_index/csr_wdata   | register write
//
// A repelling cell takes 3 squares and 11 multiplies on the shared multiplier,
// a root and two divisions; an occupied cell outside the band stops after the
// squares and the root, and an unoccupied cell takes none. A last cell adds 3
// scaling multiplies after any pending rsp word.
// Reset is synchronous, clears the sums and restores the register defaults.
// req_ready is high only when idle; a pending rsp word holds a next emit.
module repulsive_field_accumulator_core import rfa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_ROOT, ST_DIV_D, ST_DIV_M, ST_MUL_A, ST_MUL_B,
      ST_MUL_U, ST_MUL_C, ST_MUL_F, ST_CHK_LAST, ST_WAIT_OUT, ST_SCALE
   } state_type;

   state_type          state_ff;
   logic [CFG_W-1:0]   safety_ff, rgain_ff, again_ff;
   logic [COORD_W-1:0] mag_ff [3];
   logic               neg_ff [3];
   logic [SUM_W-1:0]   sum_ff [3];
   logic [SUM_W-1:0]   out_ff [3];
   logic               last_ff, issued_ff, rsp_valid_ff;
   logic [1:0]         ax_ff;
   logic [63:0]        dsq_ff, t_ff, b_ff;
   logic [COORD_W-1:0] d_ff;
   logic [INV_W-1:0]   inv_d_ff, inv_m_ff;

   mul_cmd_type        mcmd;
   logic               mul_done, sq_done, div_done, sq_start, div_start;
   logic [63:0]        mul_res;
   logic [COORD_W-1:0] sq_root, div_den;
   logic [INV_W-1:0]   div_q;
   logic [COORD_W-1:0] in_mag [3];
   logic               in_neg [3];
   logic [COORD_W-1:0] in_pt  [3];

   assign in_pt[0] = req_data.point_x;
   assign in_pt[1] = req_data.point_y;
   assign in_pt[2] = req_data.point_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_mag[i] = in_pt[i][COORD_W-1] ? (~in_pt[i] + COORD_W'(1)) : in_pt[i];
         in_neg[i] = !in_pt[i][COORD_W-1] && (in_pt[i] != '0);
      end
   end

   always_comb begin
      mcmd.start = 1'b0;
      mcmd.a     = '0;
      mcmd.b     = '0;
      mcmd.shift = SH32;
      mcmd.cap   = U64_MAX;
      case (state_ff)
         ST_SQ: begin
            mcmd.start = !issued_ff;
            mcmd.a     = 64'(mag_ff[ax_ff]);
            mcmd.b     = 64'(mag_ff[ax_ff]);
            mcmd.shift = SH0;
         end
         ST_MUL_A: begin
            mcmd.start = !issued_ff;
            mcmd.a     = 64'(inv_d_ff - inv_m_ff);
            mcmd.b     = 64'(inv_d_ff);
         end
         ST_MUL_B: begin
            mcmd.start = !issued_ff;
            mcmd.a     = t_ff;
            mcmd.b     = 64'(inv_d_ff);
         end
         ST_MUL_U: begin
            mcmd.start = !issued_ff;
            mcmd.a     = 64'(mag_ff[ax_ff]);
            mcmd.b     = 64'(inv_d_ff);
            mcmd.shift = SH16;
         end
         ST_MUL_C: begin
            mcmd.start = !issued_ff;
            mcmd.a     = b_ff;
            mcmd.b     = t_ff;
         end
         ST_MUL_F: begin
            mcmd.start = !issued_ff;
            mcmd.a     = t_ff;
            mcmd.b     = 64'(rgain_ff);
            mcmd.cap   = neg_ff[ax_ff] ? NEG_CAP : POS_CAP;
         end
         ST_SCALE: begin
            mcmd.start = !issued_ff;
            mcmd.a     = mag_of(sum_ff[ax_ff]);
            mcmd.b     = 64'(again_ff);
            mcmd.shift = SH16;
            mcmd.cap   = sum_ff[ax_ff][SUM_W-1] ? NEG_CAP : POS_CAP;
         end
         default: ;
      endcase
   end

   assign sq_start  = (state_ff == ST_ROOT) && !issued_ff;
   assign div_start = (state_ff == ST_DIV_D || state_ff == ST_DIV_M) && !issued_ff;
   assign div_den   = (state_ff == ST_DIV_D) ? d_ff : {1'b0, safety_ff};

   rfa_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mcmd),
      .done   (mul_done),
      .result (mul_res)
   );

   rfa_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (dsq_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   rfa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         safety_ff <= SAFETY_RESET;
         rgain_ff  <= GAIN_RESET;
         again_ff  <= GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAFETY: safety_ff <= csr_wdata;
            CSR_RGAIN:  rgain_ff  <= csr_wdata;
            CSR_AGAIN:  again_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mcmd.start || sq_start || div_start) begin
            issued_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= in_mag[i];
                     neg_ff[i] <= in_neg[i];
                  end
                  last_ff  <= req_data.last_cell;
                  dsq_ff   <= '0;
                  ax_ff    <= '0;
                  state_ff <= req_data.occupied ? ST_SQ : ST_CHK_LAST;
               end
            end
            ST_SQ: begin
               if (mul_done) begin
                  issued_ff <= 1'b0;
                  dsq_ff    <= dsq_ff + mul_res;
                  if (ax_ff == 2'd2) begin
                     ax_ff    <= '0;
                     state_ff <= ST_ROOT;
                  end else begin
                     ax_ff <= ax_ff + 2'd1;
                  end
               end
            end
            ST_ROOT: begin
               if (sq_done) begin
                  issued_ff <= 1'b0;
                  d_ff      <= sq_root;
                  state_ff  <= (sq_root > DIST_FLOOR && sq_root < {1'b0, safety_ff})
                               ? ST_DIV_D : ST_CHK_LAST;
               end
            end
            ST_DIV_D: begin
               if (div_done) begin
                  issued_ff <= 1'b0;
                  inv_d_ff  <= div_q;
                  state_ff  <= ST_DIV_M;
               end
            end
            ST_DIV_M: begin
               if (div_done) begin
                  issued_ff <= 1'b0;
                  inv_m_ff  <= div_q;
                  state_ff  <= ST_MUL_A;
               end
            end
            ST_MUL_A: begin
               if (mul_done) begin
                  issued_ff <= 1'b0;
                  t_ff      <= mul_res;
                  state_ff  <= ST_MUL_B;
               end
            end
            ST_MUL_B: begin
               if (mul_done) begin
                  issued_ff <= 1'b0;
                  b_ff      <= mul_res;
                  ax_ff     <= '0;
                  state_ff  <= ST_MUL_U;
               end
            end
            ST_MUL_U: begin
               if (mul_done) begin
                  issued_ff <= 1'b0;
                  t_ff      <= mul_res;
                  state_ff  <= ST_MUL_C;
               end
            end
            ST_MUL_C: begin
               if (mul_done) begin
                  issued_ff <= 1'b0;
                  t_ff      <= mul_res;
                  state_ff  <= ST_MUL_F;
               end
            end
            ST_MUL_F: begin
               if (mul_done) begin
                  issued_ff     <= 1'b0;
                  sum_ff[ax_ff] <= sat_add(sum_ff[ax_ff], apply_sign(mul_res, neg_ff[ax_ff]));
                  if (ax_ff == 2'd2) begin
                     ax_ff    <= '0;
                     state_ff <= ST_CHK_LAST;
                  end else begin
                     ax_ff    <= ax_ff + 2'd1;
                     state_ff <= ST_MUL_U;
                  end
               end
            end
            ST_CHK_LAST: begin
               ax_ff    <= '0;
               state_ff <= last_ff ? ST_WAIT_OUT : ST_IDLE;
            end
            ST_WAIT_OUT: begin
               if (!rsp_valid_ff) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (mul_done) begin
                  issued_ff     <= 1'b0;
                  out_ff[ax_ff] <= apply_sign(mul_res, sum_ff[ax_ff][SUM_W-1]);
                  if (ax_ff == 2'd2) begin
                     ax_ff        <= '0;
                     rsp_valid_ff <= 1'b1;
                     for (int i = 0; i < 3; i++) begin
                        sum_ff[i] <= '0;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     ax_ff <= ax_ff + 2'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data.accel_x = out_ff[0];
   assign rsp_data.accel_y = out_ff[1];
   assign rsp_data.accel_z = out_ff[2];

endmodule

// ----- bench/repulsive_field_accumulator_core_tb.sv -----
// Testbench for repulsive_field_accumulator_core: directed and random map scans
// checked word by word against a built-in fixed-point force predictor.
// Depends on rfa_pkg and the core RTL.
`timescale 1ns / 100ps

module repulsive_field_accumulator_core_tb;
   import rfa_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);
   localparam logic [63:0] ALL_ONES = {64{1'b1}};
   localparam longint FORCE_MAX = (64'sd1 <<< 47) - 1;
   localparam longint FORCE_MIN = -(64'sd1 <<< 47);
   localparam int SETTLE_CYCLES = 400;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_type      req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type      rsp_data;
   logic         csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   logic [63:0] safety_q, rgain_q, again_q;
   longint      acc_x, acc_y, acc_z;
   rsp_type     accel_q[$];
   int          mismatches, cells_sent, scans_checked;
   int          send_idle_pct, recv_stall_pct;

   repulsive_field_accumulator_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [63:0] mul_scaled(logic [63:0] a, logic [63:0] b, int s,
                                              logic [63:0] cap);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> s;
      return (p > {64'd0, cap}) ? cap : p[63:0];
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint clamp_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > FORCE_MAX) return FORCE_MAX;
      if (s < FORCE_MIN) return FORCE_MIN;
      return s;
   endfunction

   function automatic longint push_along(longint p, logic [63:0] b, logic [63:0] inv_d);
      logic [63:0] pm, u, c, f;
      logic        neg;
      neg = p > 0;
      pm = (p < 0) ? -p : p;
      u = mul_scaled(pm, inv_d, 16, ALL_ONES);
      c = mul_scaled(b, u, 32, ALL_ONES);
      f = mul_scaled(c, rgain_q, 32, neg ? 64'd1 << 47 : (64'd1 << 47) - 1);
      return neg ? -longint'(f) : longint'(f);
   endfunction

   function automatic logic [SUM_W-1:0] scaled_accel(longint s);
      logic [63:0] m;
      longint      v;
      m = mul_scaled((s < 0) ? -s : s, again_q, 16,
                     (s < 0) ? 64'd1 << 47 : (64'd1 << 47) - 1);
      v = (s < 0) ? -longint'(m) : longint'(m);
      return v[SUM_W-1:0];
   endfunction

   task automatic accumulate_cell(req_type w);
      longint      x, y, z;
      logic [63:0] dsq, d, inv_d, inv_m, a, b;
      rsp_type     r;
      if (w.occupied) begin
         x = longint'($signed(w.point_x));
         y = longint'($signed(w.point_y));
         z = longint'($signed(w.point_z));
         dsq = x * x + y * y + z * z;
         d = root_floor(dsq);
         if (d > 65 && d < safety_q) begin
            inv_d = (64'd1 << 48) / d;
            inv_m = (64'd1 << 48) / safety_q;
            a = mul_scaled(inv_d - inv_m, inv_d, 32, ALL_ONES);
            b = mul_scaled(a, inv_d, 32, ALL_ONES);
            acc_x = clamp_add(acc_x, push_along(x, b, inv_d));
            acc_y = clamp_add(acc_y, push_along(y, b, inv_d));
            acc_z = clamp_add(acc_z, push_along(z, b, inv_d));
         end
      end
      if (w.last_cell) begin
         r.accel_x = scaled_accel(acc_x);
         r.accel_y = scaled_accel(acc_y);
         r.accel_z = scaled_accel(acc_z);
         accel_q.push_back(r);
         acc_x = 0;
         acc_y = 0;
         acc_z = 0;
      end
   endtask

   task automatic report(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (accel_q.size() == 0) begin
            report("unexpected word", rsp_data.accel_x, '0);
         end else begin
            want = accel_q.pop_front();
            scans_checked++;
            if (rsp_data.accel_x !== want.accel_x) report("accel_x", rsp_data.accel_x, want.accel_x);
            if (rsp_data.accel_y !== want.accel_y) report("accel_y", rsp_data.accel_y, want.accel_y);
            if (rsp_data.accel_z !== want.accel_z) report("accel_z", rsp_data.accel_z, want.accel_z);
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_cell(req_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = w;
      do @(posedge clock); while (!req_ready);
      accumulate_cell(w);
      cells_sent++;
   endtask

   function automatic req_type make_cell(logic occ, int x, int y, int z, logic last);
      req_type w;
      w.occupied = occ;
      w.point_x = x;
      w.point_y = y;
      w.point_z = z;
      w.last_cell = last;
      return w;
   endfunction

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (accel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      drain();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SAFETY: safety_q = val;
         CSR_RGAIN:  rgain_q = val;
         CSR_AGAIN:  again_q = val;
         default: ;
      endcase
   endtask

   function automatic int pick_coord();
      int lim, m;
      lim = (safety_q > 64'd2000000) ? 2000000 : int'(safety_q) / 2 + 1;
      case ($urandom_range(9))
         0: m = 0;
         1: return int'($urandom);
         2: m = $urandom_range(200);
         default: m = $urandom_range(lim);
      endcase
      return $urandom_range(1) ? -m : m;
   endfunction

   task automatic test_directed();
      send_cell(make_cell(1, 32'h0001_0000, 0, 0, 1));
      send_cell(make_cell(0, 32'h0000_8000, 0, 0, 1));
      send_cell(make_cell(1, 10, 20, 0, 0));
      send_cell(make_cell(1, 32'h0028_0000, 0, 0, 1));
      send_cell(make_cell(1, 0, -32'sh0002_0000, 32'h0003_0000, 0));
      send_cell(make_cell(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
      send_cell(make_cell(1, 66, 0, 0, 0));
      send_cell(make_cell(1, 0, 0, -66, 0));
      send_cell(make_cell(1, -32'sh0000_4000, 32'h0000_4000, -32'sh0000_2000, 1));
      write_reg(CSR_SAFETY, '0);
      send_cell(make_cell(1, 32'h0000_8000, 0, 0, 1));
      write_reg(CSR_SAFETY, {CFG_W{1'b1}});
      write_reg(CSR_RGAIN, {CFG_W{1'b1}});
      write_reg(CSR_AGAIN, {CFG_W{1'b1}});
      repeat (4) send_cell(make_cell(1, 70, 0, 0, 0));
      repeat (4) send_cell(make_cell(1, 0, -70, 70, 0));
      send_cell(make_cell(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
      write_reg(CSR_AGAIN, '0);
      send_cell(make_cell(1, 32'h0001_0000, 32'h0001_0000, 0, 1));
      write_reg(CSR_UNUSED, 31'h1234_5678);
      send_cell(make_cell(1, 32'h0001_0000, 0, 0, 1));
   endtask

   task automatic test_random(int items, int idle_pct, int stall_pct);
      int len;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      while (items > 0) begin
         len = $urandom_range(8, 1);
         for (int i = 0; i < len; i++)
            send_cell(make_cell($urandom_range(9) != 0, pick_coord(), pick_coord(),
                                pick_coord(), i == len - 1));
         items -= len;
         if ($urandom_range(19) == 0) send_cell(make_cell($urandom_range(1), $urandom,
                                                          $urandom, $urandom,
                                                          $urandom_range(1)));
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      cells_sent = 0;
      scans_checked = 0;
      safety_q = SAFETY_RESET;
      rgain_q = GAIN_RESET;
      again_q = GAIN_RESET;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      write_reg(CSR_SAFETY, SAFETY_RESET);
      write_reg(CSR_RGAIN, GAIN_RESET);
      write_reg(CSR_AGAIN, GAIN_RESET);
      test_random(330, 0, 0);
      write_reg(CSR_SAFETY, 31'h0000_4000);
      write_reg(CSR_RGAIN, 31'h0100_0000);
      test_random(330, 74, 0);
      write_reg(CSR_SAFETY, {CFG_W{1'b1}});
      write_reg(CSR_RGAIN, 31'h0000_0100);
      write_reg(CSR_AGAIN, 31'h0040_0000);
      test_random(330, 0, 74);
      write_reg(CSR_SAFETY, 31'h0010_0000);
      write_reg(CSR_RGAIN, {CFG_W{1'b1}});
      write_reg(CSR_AGAIN, 31'h0000_0001);
      test_random(330, 16, 16);
      drain();

      $display("covered %0d cells and %0d scans over several register settings",
               cells_sent, scans_checked);
      $display("idle mixes: none, sender gaps, receiver stalls, both; %0d mismatches",
               mismatches);
      if (mismatches == 0 && accel_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
